@@ hdl/vn_pkg.sv @@
package vn_pkg;

    localparam int NSTEP = 16;   // one root / quotient bit per step

    // Word as it travels down the bit-step pipeline
    typedef struct packed {
        logic        vld;
        logic        nx;
        logic        ny;
        logic        zero;
        logic [31:0] s;      // x^2 + y^2
        logic [32:0] srem;   // s - root^2
        logic [15:0] root;
        logic [63:0] rx;     // ax^2 * 2^28 - qx^2 * s
        logic [63:0] ry;
        logic [47:0] qsx;    // qx * s
        logic [47:0] qsy;
        logic [14:0] qx;
        logic [14:0] qy;
    } t_lane;

endpackage

@@ hdl/vn_prep.sv @@
module vn_prep
    import vn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_ce,
    input  logic        i_vld,
    input  logic [15:0] i_vec_x,
    input  logic [15:0] i_vec_y,
    output t_lane       o_lane
);

    logic [16:0] ax, ay;
    logic [33:0] sqx, sqy;
    t_lane       n_lane, r_lane;

    // magnitude of two's complement, -32768 gives 32768
    assign ax  = i_vec_x[15] ? (17'h10000 - {1'b0, i_vec_x}) : {1'b0, i_vec_x};
    assign ay  = i_vec_y[15] ? (17'h10000 - {1'b0, i_vec_y}) : {1'b0, i_vec_y};
    assign sqx = ax * ax;
    assign sqy = ay * ay;

    always_comb begin
        n_lane      = '0;
        n_lane.vld  = i_vld;
        n_lane.nx   = i_vec_x[15];
        n_lane.ny   = i_vec_y[15];
        n_lane.zero = (i_vec_x == 16'd0) && (i_vec_y == 16'd0);
        n_lane.s    = sqx[31:0] + sqy[31:0];
        n_lane.srem = {1'b0, n_lane.s};
        n_lane.rx   = {30'd0, sqx} << 28;
        n_lane.ry   = {30'd0, sqy} << 28;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.vld <= 1'b0;
        end else if (i_ce) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

@@ hdl/vn_step.sv @@
module vn_step
    import vn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_ce,
    input  logic [3:0] i_k,      // bit position handled here, tied off
    input  t_lane      i_lane,
    output t_lane      o_lane
);

    logic [32:0] inc_r;
    logic [63:0] inc_x, inc_y;
    logic [47:0] s_sh;
    logic        do_q;
    t_lane       n_lane, r_lane;

    // (r+b)^2 - r^2 = 2rb + b^2
    assign inc_r = ({17'd0, i_lane.root} << ({1'b0, i_k} + 5'd1))
                 | (33'd1 << {i_k, 1'b0});
    // (q+b)^2 s - q^2 s = 2b qs + b^2 s
    assign inc_x = ({16'd0, i_lane.qsx} << ({1'b0, i_k} + 5'd1))
                 + ({32'd0, i_lane.s} << {i_k, 1'b0});
    assign inc_y = ({16'd0, i_lane.qsy} << ({1'b0, i_k} + 5'd1))
                 + ({32'd0, i_lane.s} << {i_k, 1'b0});
    assign s_sh  = {16'd0, i_lane.s} << i_k;
    assign do_q  = (i_k != 4'd15);   // quotient has bits 14..0 only

    always_comb begin
        n_lane = i_lane;
        if (i_lane.srem >= inc_r) begin
            n_lane.srem = i_lane.srem - inc_r;
            n_lane.root = i_lane.root | (16'd1 << i_k);
        end
        if (do_q && (i_lane.rx >= inc_x)) begin
            n_lane.rx  = i_lane.rx - inc_x;
            n_lane.qsx = i_lane.qsx + s_sh;
            n_lane.qx  = i_lane.qx | (15'd1 << i_k);
        end
        if (do_q && (i_lane.ry >= inc_y)) begin
            n_lane.ry  = i_lane.ry - inc_y;
            n_lane.qsy = i_lane.qsy + s_sh;
            n_lane.qy  = i_lane.qy | (15'd1 << i_k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.vld <= 1'b0;
        end else if (i_ce) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

@@ hdl/vn_out.sv @@
module vn_out
    import vn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_ce,
    input  t_lane       i_lane,
    output logic        o_vld,
    output logic [47:0] o_data,
    output logic        o_zero
);

    logic [15:0] ux, uy;
    logic        r_vld, r_zero;
    logic [47:0] r_data;

    assign ux = i_lane.nx ? (16'd0 - {1'b0, i_lane.qx}) : {1'b0, i_lane.qx};
    assign uy = i_lane.ny ? (16'd0 - {1'b0, i_lane.qy}) : {1'b0, i_lane.qy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ce) begin
            r_vld <= i_lane.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_zero <= i_lane.zero;
            r_data <= i_lane.zero ? 48'd0 : {i_lane.root, uy, ux};
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;
    assign o_zero = r_zero;

endmodule

@@ hdl/vector2_normalise.sv @@
// Pipeline: input word to result word through 1 square stage, 16 bit steps and 1 output register.
// Throughput: one word per cycle; a shared clock enable stalls the whole pipe
// only while a result sits unaccepted at the output.
// Reset: synchronous, active low; clears every valid bit, the pipe comes up empty.
module vector2_normalise
    import vn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // vec_x [15:0], vec_y [31:16]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // unit_x [15:0], unit_y [31:16], magnitude [47:32]
    output logic        o_m_tuser    // is_zero
);

    t_lane lane [0:NSTEP];
    logic  ce;

    // advance whenever the output slot is free or being taken
    assign ce         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = ce;

    // abs values and squares; seeds all three remainders
    vn_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (i_s_tvalid),
        .i_vec_x (i_s_tdata[15:0]),
        .i_vec_y (i_s_tdata[31:16]),
        .o_lane  (lane[0])
    );

    // restoring digit steps: root bit and both quotient bits from MSB down
    for (genvar g = 0; g < NSTEP; g++) begin : g_step
        vn_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (ce),
            .i_k     (4'(NSTEP - 1 - g)),
            .i_lane  (lane[g]),
            .o_lane  (lane[g+1])
        );
    end

    // sign restore, zero-vector override, output register
    vn_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_lane  (lane[NSTEP]),
        .o_vld   (o_m_tvalid),
        .o_data  (o_m_tdata),
        .o_zero  (o_m_tuser)
    );

endmodule

@@ hdl/vn_check.sv @@
module vn_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata,
    input logic        o_m_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled word changed");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == 48'd0)
        else $error("zero vector with nonzero result");

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[47:32] != 16'd0)
        else $error("nonzero vector with zero length");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("valid after reset");

endmodule

bind vector2_normalise vn_check u_vn_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
